// File: src/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, codes and saturating Q16.16 helpers for the platoon spacing
// controller.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int COUNT_W  = 7;
    localparam int SLOT_W   = 6;
    localparam int DATA_W   = 32;
    localparam int DT_W     = 31;
    localparam int PADDR_W  = 5;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // result status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_FEW = 1'b1;

    // register indexes
    localparam logic [2:0] REG_COUNT   = 3'd0;
    localparam logic [2:0] REG_DT      = 3'd1;
    localparam logic [2:0] REG_GAP     = 3'd2;
    localparam logic [2:0] REG_KP      = 3'd3;
    localparam logic [2:0] REG_KV      = 3'd4;
    localparam logic [2:0] REG_AUPPER  = 3'd5;
    localparam logic [2:0] REG_ALOWER  = 3'd6;

    // register reset values
    localparam logic [COUNT_W-1:0]       RST_COUNT  = 7'd0;
    localparam logic [DT_W-1:0]          RST_DT     = 31'd6554;
    localparam logic signed [DATA_W-1:0] RST_GAP    = 32'sd655360;
    localparam logic signed [DATA_W-1:0] RST_KP     = 32'sd32768;
    localparam logic signed [DATA_W-1:0] RST_KV     = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_AUPPER = 32'sd196608;
    localparam logic signed [DATA_W-1:0] RST_ALOWER = -32'sd327680;

    typedef struct packed {
        logic [COUNT_W-1:0]       vehicle_count;
        logic [DT_W-1:0]          time_step;
        logic signed [DATA_W-1:0] desired_gap;
        logic signed [DATA_W-1:0] spacing_gain;
        logic signed [DATA_W-1:0] speed_gain;
        logic signed [DATA_W-1:0] accel_upper;
        logic signed [DATA_W-1:0] accel_lower;
    } cfg_t;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_KP_ERR = 2'd0,
        MUL_KV_DV  = 2'd1,
        MUL_ACC_DT = 2'd2,
        MUL_SPD_DT = 2'd3
    } mul_sel_t;

    // controller to datapath
    typedef struct packed {
        logic               load_wr;
        logic               read_en;
        logic               diff_en;
        logic               err_en;
        logic               mul_en;
        mul_sel_t           mul_sel;
        logic               t1_en;
        logic               sum_en;
        logic               clamp_en;
        logic               spd_en;
        logic               pos_en;
        logic               fail_load;
        logic               leader;
        logic               last;
        logic [COUNT_W-1:0] idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } stat_t;

    // clip a 33-bit signed value into 32 bits
    function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[DATA_W] != v[DATA_W-1])
            r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        return sat33(s);
    endfunction

    // q16.16 product scaling: floor shift by 16, then clip to 32 bits
    function automatic logic signed [DATA_W-1:0] qscale(input logic signed [2*DATA_W-1:0] p);
        logic signed [DATA_W-1:0] r;
        if ((&p[63:47]) || !(|p[63:47]))
            r = p[47:16];
        else
            r = p[63] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

endpackage

// File: src/psc_regs.sv
// ----------------------------------------------------------------------------
// psc_regs
// Configuration register file behind a simple apb-style port.
// ----------------------------------------------------------------------------
module psc_regs
    import psc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vehicle_count <= RST_COUNT;
            cfg_reg.time_step     <= RST_DT;
            cfg_reg.desired_gap   <= RST_GAP;
            cfg_reg.spacing_gain  <= RST_KP;
            cfg_reg.speed_gain    <= RST_KV;
            cfg_reg.accel_upper   <= RST_AUPPER;
            cfg_reg.accel_lower   <= RST_ALOWER;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_COUNT:  cfg_reg.vehicle_count <= pwdata[COUNT_W-1:0];
                REG_DT:     cfg_reg.time_step     <= pwdata[DT_W-1:0];
                REG_GAP:    cfg_reg.desired_gap   <= pwdata;
                REG_KP:     cfg_reg.spacing_gain  <= pwdata;
                REG_KV:     cfg_reg.speed_gain    <= pwdata;
                REG_AUPPER: cfg_reg.accel_upper   <= pwdata;
                REG_ALOWER: cfg_reg.accel_lower   <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COUNT:  prdata = {25'd0, cfg_reg.vehicle_count};
            REG_DT:     prdata = {1'b0, cfg_reg.time_step};
            REG_GAP:    prdata = cfg_reg.desired_gap;
            REG_KP:     prdata = cfg_reg.spacing_gain;
            REG_KV:     prdata = cfg_reg.speed_gain;
            REG_AUPPER: prdata = cfg_reg.accel_upper;
            REG_ALOWER: prdata = cfg_reg.accel_lower;
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// File: src/psc_dp.sv
// ----------------------------------------------------------------------------
// psc_dp
// Datapath: vehicle state memories, shared multiplier, saturating adders,
// predecessor registers and the result register.
// ----------------------------------------------------------------------------
module psc_dp
    import psc_pkg::*;
#(
    parameter int MAX_VEHICLES = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  cfg_t                     cfg,
    input  logic [SLOT_W-1:0]        vehicle_slot,
    input  logic signed [DATA_W-1:0] load_position,
    input  logic signed [DATA_W-1:0] load_speed,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [SLOT_W-1:0]        vehicle_number,
    output logic signed [DATA_W-1:0] new_position,
    output logic signed [DATA_W-1:0] new_speed,
    output logic signed [DATA_W-1:0] gap_error,
    output logic                     status,
    output logic                     last
);

    localparam int ADDR_W = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;

    logic signed [DATA_W-1:0] pos_mem [MAX_VEHICLES];
    logic signed [DATA_W-1:0] spd_mem [MAX_VEHICLES];

    logic signed [DATA_W-1:0]   old_reg, spd_reg;
    logic signed [DATA_W-1:0]   gap_reg, dv_reg, err_reg;
    logic signed [DATA_W-1:0]   t1_reg, acc_reg;
    logic signed [2*DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0]   pred_pos_reg, pred_spd_reg;

    logic                     out_valid_reg;
    logic [SLOT_W-1:0]        num_reg;
    logic signed [DATA_W-1:0] opos_reg, ospd_reg, oerr_reg;
    logic                     ostat_reg, olast_reg;

    logic                     slot_ok;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic signed [DATA_W-1:0] wr_pos, wr_spd;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [DATA_W-1:0] dt_s;
    logic signed [DATA_W-1:0] pos_new, spd_sum;
    logic                     out_free;

    assign dt_s     = {1'b0, cfg.time_step};
    assign slot_ok  = (32'(vehicle_slot) < MAX_VEHICLES);
    assign rd_addr  = ADDR_W'(cmd.idx);
    assign pos_new  = sat_add(old_reg, qscale(prod_reg));
    assign spd_sum  = sat_add(spd_reg, qscale(prod_reg));
    assign out_free = !out_valid_reg || !out_stall;
    assign stat.out_free = out_free;

    // one write port per memory: load items or the commit of a stepped vehicle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr;
        wr_pos  = pos_new;
        wr_spd  = spd_reg;
        if (cmd.load_wr)
        begin
            wr_en   = slot_ok;
            wr_addr = ADDR_W'(vehicle_slot);
            wr_pos  = load_position;
            wr_spd  = load_speed;
        end
        else if (cmd.pos_en)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_mem[wr_addr] <= wr_pos;
            spd_mem[wr_addr] <= wr_spd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            old_reg <= pos_mem[rd_addr];
        end
    end

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_KP_ERR: begin mul_a = cfg.spacing_gain; mul_b = err_reg; end
            MUL_KV_DV:  begin mul_a = cfg.speed_gain;   mul_b = dv_reg;  end
            MUL_ACC_DT: begin mul_a = acc_reg;          mul_b = dt_s;    end
            MUL_SPD_DT: begin mul_a = spd_reg;          mul_b = dt_s;    end
            default:    begin mul_a = spd_reg;          mul_b = dt_s;    end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            spd_reg <= spd_mem[rd_addr];
        end
        else if (cmd.spd_en)
        begin
            spd_reg <= spd_sum[DATA_W-1] ? '0 : spd_sum;
        end

        if (cmd.diff_en)
        begin
            gap_reg <= sat_sub(pred_pos_reg, old_reg);
            dv_reg  <= sat_sub(pred_spd_reg, spd_reg);
        end

        if (cmd.err_en)
        begin
            err_reg <= sat_sub(gap_reg, cfg.desired_gap);
        end

        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end

        if (cmd.t1_en)
        begin
            t1_reg <= qscale(prod_reg);
        end

        // lower limit first, then upper limit, so a crossed lower limit wins
        if (cmd.sum_en)
        begin
            acc_reg <= sat_add(t1_reg, qscale(prod_reg));
        end
        else if (cmd.clamp_en)
        begin
            if (acc_reg < cfg.accel_lower)
                acc_reg <= cfg.accel_lower;
            else if (acc_reg > cfg.accel_upper)
                acc_reg <= (cfg.accel_upper < cfg.accel_lower) ? cfg.accel_lower
                                                               : cfg.accel_upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_pos_reg <= '0;
            pred_spd_reg <= '0;
        end
        else if (cmd.pos_en)
        begin
            pred_pos_reg <= old_reg;
            pred_spd_reg <= spd_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pos_en || cmd.fail_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_en)
        begin
            num_reg   <= cmd.idx[SLOT_W-1:0];
            opos_reg  <= pos_new;
            ospd_reg  <= spd_reg;
            oerr_reg  <= cmd.leader ? '0 : err_reg;
            ostat_reg <= ST_OK;
            olast_reg <= cmd.last;
        end
        else if (cmd.fail_load)
        begin
            num_reg   <= '0;
            opos_reg  <= '0;
            ospd_reg  <= '0;
            oerr_reg  <= '0;
            ostat_reg <= ST_FEW;
            olast_reg <= 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign vehicle_number = num_reg;
    assign new_position   = opos_reg;
    assign new_speed      = ospd_reg;
    assign gap_error      = oerr_reg;
    assign status         = ostat_reg;
    assign last           = olast_reg;

endmodule

// File: src/psc_ctrl.sv
// ----------------------------------------------------------------------------
// psc_ctrl
// Sequencer: accepts requests and walks the vehicles one at a time through
// the shared datapath.
// ----------------------------------------------------------------------------
module psc_ctrl
    import psc_pkg::*;
#(
    parameter int MAX_VEHICLES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [COUNT_W-1:0] vehicle_count,
    input  stat_t              stat,
    output cmd_t               cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_FAIL  = 13'b0000000000010,
        S_READ  = 13'b0000000000100,
        S_DIFF  = 13'b0000000001000,
        S_ERR   = 13'b0000000010000,
        S_MUL1  = 13'b0000000100000,
        S_MUL2  = 13'b0000001000000,
        S_SUM   = 13'b0000010000000,
        S_CLAMP = 13'b0000100000000,
        S_MUL3  = 13'b0001000000000,
        S_SPD   = 13'b0010000000000,
        S_MUL4  = 13'b0100000000000,
        S_POS   = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] n_use;
    logic [COUNT_W-1:0] idx_inc;
    logic               accept;
    logic               leader;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign n_use    = (32'(vehicle_count) > MAX_VEHICLES) ? COUNT_W'(MAX_VEHICLES)
                                                          : vehicle_count;
    assign idx_inc  = idx_reg + COUNT_W'(1);
    assign leader   = (idx_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;

        cmd           = '0;
        cmd.mul_sel   = MUL_SPD_DT;
        cmd.idx       = idx_reg;
        cmd.leader    = leader;
        cmd.last      = (idx_inc == n_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else if (n_use < COUNT_W'(2))
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        n_next     = n_use;
                        idx_next   = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_FAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.fail_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.read_en = 1'b1;
                state_next  = leader ? S_MUL4 : S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = S_ERR;
            end
            S_ERR:
            begin
                cmd.err_en = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KP_ERR;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.t1_en   = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KV_DV;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp_en = 1'b1;
                state_next   = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ACC_DT;
                state_next  = S_SPD;
            end
            S_SPD:
            begin
                cmd.spd_en = 1'b1;
                state_next = S_MUL4;
            end
            S_MUL4:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SPD_DT;
                state_next  = S_POS;
            end
            S_POS:
            begin
                if (stat.out_free)
                begin
                    cmd.pos_en = 1'b1;
                    if (idx_inc == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

endmodule

// File: src/platoon_spacing_controller.sv
// ----------------------------------------------------------------------------
// platoon_spacing_controller
// Predecessor-following longitudinal control of a vehicle platoon in Q16.16.
//
// Usage:
//   request channel (in_valid / in_stall): a load request writes position and
//   speed of one vehicle slot and produces no result; a step request advances
//   every vehicle in use and produces one result per vehicle, in slot order,
//   the final one flagged by last. With fewer than two vehicles in use a step
//   produces a single result with status set.
//   result channel (out_valid / out_stall): a one-entry result register; the
//   sequencer keeps working on the next vehicle while a result waits.
//   Sequencing: a load leaves the sequencer idle; an error step visits S_FAIL.
//   A step runs the leader through S_READ, S_MUL4 and S_POS, and each follower
//   through S_READ, S_DIFF, S_ERR, S_MUL1, S_MUL2, S_SUM, S_CLAMP, S_MUL3,
//   S_SPD, S_MUL4, S_POS: four uses of the single shared 32x32 multiplier.
//   Reset clears the control state and restores the register defaults; the
//   vehicle store holds no defined values until loaded.
//   A stalled receiver freezes the result register; the sequencer then waits
//   at the end of the next vehicle and in_stall stays high until done.
//   The user must write registers through the apb-style port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module platoon_spacing_controller
    import psc_pkg::*;
#(
    parameter int MAX_VEHICLES = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    // request channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     operation,
    input  logic [SLOT_W-1:0]        vehicle_slot,
    input  logic signed [DATA_W-1:0] load_position,
    input  logic signed [DATA_W-1:0] load_speed,

    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [SLOT_W-1:0]        vehicle_number,
    output logic signed [DATA_W-1:0] new_position,
    output logic signed [DATA_W-1:0] new_speed,
    output logic signed [DATA_W-1:0] gap_error,
    output logic                     status,
    output logic                     last
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // register file; the user must keep it static while a request is in flight, the block does not enforce it
    psc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: one vehicle at a time through the datapath
    psc_ctrl #(
        .MAX_VEHICLES (MAX_VEHICLES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .vehicle_count (cfg.vehicle_count),
        .stat          (stat),
        .cmd           (cmd)
    );

    // vehicle store, multiplier, saturation and result register
    psc_dp #(
        .MAX_VEHICLES (MAX_VEHICLES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg            (cfg),
        .vehicle_slot   (vehicle_slot),
        .load_position  (load_position),
        .load_speed     (load_speed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vehicle_number (vehicle_number),
        .new_position   (new_position),
        .new_speed      (new_speed),
        .gap_error      (gap_error),
        .status         (status),
        .last           (last)
    );

endmodule
